// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define LESN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition implies expression in the following cycle
`define LESN_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

// ----- rtl/lesn_pkg.sv -----
// types, constants and fixed-point helpers of the lorenz euler stepper
`default_nettype none

package lesn_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int RHO_W   = 23;
  localparam int SIGMA_W = 23;
  localparam int BETA_W  = 20;
  localparam int DT_W    = 17;
  localparam int CFG_W   = 23;
  localparam int CFG_AW  = 3;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic        [WORD_BITS-1:0]   mag_t;
  typedef logic        [2*WORD_BITS-1:0] prod_t;
  typedef logic        [WORD_BITS-2:0]   peak_t;

  localparam mag_t  WMAX_U = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_FX = {{(WORD_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [RHO_W-1:0]   RHO_RESET   = 23'd1638400;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 23'd655360;
  localparam logic [BETA_W-1:0]  BETA_RESET  = 20'd174763;
  localparam logic [DT_W-1:0]    DT_RESET    = 17'd655;

  typedef enum logic [CFG_AW-1:0] {
    CFG_RHO,
    CFG_SIGMA,
    CFG_BETA,
    CFG_DT,
    CFG_ZERO_DRIFT
  } cfg_idx_t;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic mag_t mag(input word_t a);
    mag_t m;
    m = a[WORD_BITS-1] ? (~mag_t'(a) + 1'b1) : mag_t'(a);
    return m;
  endfunction

  // magnitude, most negative word clamps to the largest positive word
  function automatic peak_t fx_abs(input word_t a);
    mag_t m;
    m = mag(a);
    if (m[WORD_BITS-1]) return '1;
    return m[WORD_BITS-2:0];
  endfunction

  // round to nearest, ties away from zero, then sign and saturate
  function automatic word_t fx_round(input prod_t prod, input logic neg);
    logic [2*WORD_BITS:0]           sum;
    logic [2*WORD_BITS-FRAC_BITS:0] m;
    logic [2*WORD_BITS-FRAC_BITS:0] lim;
    mag_t                           r;
    sum = {1'b0, prod} + {{(2*WORD_BITS-FRAC_BITS+1){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    m   = sum[2*WORD_BITS:FRAC_BITS];
    lim = {{(WORD_BITS-FRAC_BITS+1){1'b0}}, WMAX_U}
        + {{(2*WORD_BITS-FRAC_BITS){1'b0}}, neg};
    if (m > lim) m = lim;
    r = m[WORD_BITS-1:0];
    return neg ? word_t'(~r + 1'b1) : word_t'(r);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lorenz_euler_step_noise.sv -----
// lorenz euler stepper with noise: shared multiplier and saturating adder under a sequencer
//
// usage: the input channel carries one beat per item; in_tuser is the opcode
// (0 advance one euler step, 1 restart at (1,1,1)) and in_tdata holds the three
// signed noise increments. every input beat gives exactly one output beat with
// the new point and the largest absolute jacobian entry at that point (zero in zero-drift mode).
// a step beat runs the sequencer through S_A to S_K and then S_PK0 to S_PK2, a
// restart beat only through S_PK0 to S_PK2; in_tready is high only while the
// sequencer is idle, so no new beat is taken before the last one is through.
// the sequence is set by the single 32x32 multiplier and the single saturating
// adder, each used at most once per sequencer state.
// the result sits in an output register, so a new beat is taken while the last
// result still waits; if the receiver stalls the next result holds in the last
// sequencer state until the output register frees up.
// configuration writes land at once and are meant to happen while idle.
// reset (synchronous, active low) restores the default parameters, puts the
// point at (1,1,1) and empties the output register.
`default_nettype none

module lorenz_euler_step_noise (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [95:0]                in_tdata,   // noise_x, noise_y, noise_z
  input  wire logic                       in_tuser,   // opcode
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [127:0]                    out_tdata,  // new_x, new_y, new_z, jacobian_peak, pad
  input  wire logic                       cfg_wr_en,
  input  wire logic [lesn_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [lesn_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int W = lesn_pkg::WORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A, S_B, S_C, S_D, S_E, S_F, S_G, S_H, S_I, S_J, S_K,
    S_PK0, S_PK1, S_PK2
  } state_t;

  state_t state_r;

  logic [lesn_pkg::RHO_W-1:0]   rho_r;
  logic [lesn_pkg::SIGMA_W-1:0] sigma_r;
  logic [lesn_pkg::BETA_W-1:0]  beta_r;
  logic [lesn_pkg::DT_W-1:0]    dt_r;
  logic                         zd_r;

  lesn_pkg::word_t x_r, y_r, z_r;
  lesn_pkg::word_t ta_r, tb_r;
  lesn_pkg::word_t dx_r, dy_r, dz_r;
  lesn_pkg::word_t nx_r, ny_r, nz_r;
  lesn_pkg::prod_t prod_r;
  logic            neg_r;
  lesn_pkg::peak_t peak_r;

  logic            out_valid_r;
  lesn_pkg::word_t out_x_r, out_y_r, out_z_r;
  lesn_pkg::peak_t out_peak_r;

  lesn_pkg::word_t rho_w, sigma_w, beta_w, dt_w;

  // shared units
  lesn_pkg::word_t alu_a, alu_b, alu_y;
  logic            alu_sub;
  lesn_pkg::word_t mul_a, mul_b, mul_q;
  lesn_pkg::prod_t prod_nxt;
  lesn_pkg::word_t abs_in;
  lesn_pkg::peak_t abs_v, peak_max, peak_init, sb_max;

  logic in_acc, out_free;

  assign rho_w   = lesn_pkg::word_t'(rho_r);
  assign sigma_w = lesn_pkg::word_t'(sigma_r);
  assign beta_w  = lesn_pkg::word_t'(beta_r);
  assign dt_w    = lesn_pkg::word_t'(dt_r);

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_peak_r, out_z_r, out_y_r, out_x_r};

  // operand selection per sequencer step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    abs_in  = '0;
    case (state_r)
      S_A: begin
        alu_a = y_r;  alu_b = x_r;  alu_sub = 1'b1;
        mul_a = x_r;  mul_b = y_r;
      end
      S_B: begin
        alu_a = rho_w;  alu_b = z_r;  alu_sub = 1'b1;
        mul_a = beta_w; mul_b = z_r;
      end
      S_C: begin
        alu_a = dz_r;    alu_b = mul_q; alu_sub = 1'b1;
        mul_a = sigma_w; mul_b = ta_r;
      end
      S_D: begin
        mul_a = x_r; mul_b = tb_r;
      end
      S_E: begin
        alu_a = mul_q; alu_b = y_r; alu_sub = 1'b1;
        mul_a = dx_r;  mul_b = dt_w;
      end
      S_F: begin
        alu_a = mul_q; alu_b = nx_r;
        mul_a = dy_r;  mul_b = dt_w;
      end
      S_G: begin
        alu_a = x_r;  alu_b = ta_r;
        mul_a = dz_r; mul_b = dt_w;
      end
      S_H: begin
        alu_a = tb_r; alu_b = ny_r;
      end
      S_I: begin
        alu_a = y_r; alu_b = ta_r;
      end
      S_J: begin
        alu_a = dz_r; alu_b = nz_r;
      end
      S_K: begin
        alu_a = z_r; alu_b = ta_r;
      end
      S_PK0: begin
        alu_a = rho_w; alu_b = z_r; alu_sub = 1'b1;
        abs_in = x_r;
      end
      S_PK1: abs_in = y_r;
      S_PK2: abs_in = tb_r;
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_y    = alu_sub ? lesn_pkg::sat_sub(alu_a, alu_b) : lesn_pkg::sat_add(alu_a, alu_b);
  assign prod_nxt = lesn_pkg::prod_t'(lesn_pkg::mag(mul_a)) * lesn_pkg::prod_t'(lesn_pkg::mag(mul_b));
  assign mul_q    = lesn_pkg::fx_round(prod_r, neg_r);
  assign abs_v    = lesn_pkg::fx_abs(abs_in);
  assign peak_max = (abs_v > peak_r) ? abs_v : peak_r;

  // sigma, beta and 1.0 are fixed for the item
  assign sb_max    = (lesn_pkg::peak_t'(sigma_r) > lesn_pkg::peak_t'(beta_r)) ?
                     lesn_pkg::peak_t'(sigma_r) : lesn_pkg::peak_t'(beta_r);
  assign peak_init = (sb_max > lesn_pkg::peak_t'(lesn_pkg::ONE_FX)) ?
                     sb_max : lesn_pkg::peak_t'(lesn_pkg::ONE_FX);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= mul_a[W-1] ^ mul_b[W-1];
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rho_r       <= lesn_pkg::RHO_RESET;
      sigma_r     <= lesn_pkg::SIGMA_RESET;
      beta_r      <= lesn_pkg::BETA_RESET;
      dt_r        <= lesn_pkg::DT_RESET;
      zd_r        <= 1'b0;
      x_r         <= lesn_pkg::ONE_FX;
      y_r         <= lesn_pkg::ONE_FX;
      z_r         <= lesn_pkg::ONE_FX;
    end else begin
      if (cfg_wr_en) begin
        case (lesn_pkg::cfg_idx_t'(cfg_addr))
          lesn_pkg::CFG_RHO:        rho_r   <= cfg_wr_data[lesn_pkg::RHO_W-1:0];
          lesn_pkg::CFG_SIGMA:      sigma_r <= cfg_wr_data[lesn_pkg::SIGMA_W-1:0];
          lesn_pkg::CFG_BETA:       beta_r  <= cfg_wr_data[lesn_pkg::BETA_W-1:0];
          lesn_pkg::CFG_DT:         dt_r    <= cfg_wr_data[lesn_pkg::DT_W-1:0];
          lesn_pkg::CFG_ZERO_DRIFT: zd_r    <= cfg_wr_data[0];
          default: ;
        endcase
      end

      if (state_r == S_PK2 && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            nx_r   <= lesn_pkg::word_t'(in_tdata[31:0]);
            ny_r   <= lesn_pkg::word_t'(in_tdata[63:32]);
            nz_r   <= lesn_pkg::word_t'(in_tdata[95:64]);
            peak_r <= peak_init;
            if (in_tuser) begin
              x_r     <= lesn_pkg::ONE_FX;
              y_r     <= lesn_pkg::ONE_FX;
              z_r     <= lesn_pkg::ONE_FX;
              state_r <= S_PK0;
            end else begin
              state_r <= S_A;
            end
          end
        end
        S_A: begin
          ta_r    <= alu_y;
          state_r <= S_B;
        end
        S_B: begin
          tb_r    <= alu_y;
          dz_r    <= mul_q;
          state_r <= S_C;
        end
        S_C: begin
          dz_r    <= zd_r ? '0 : alu_y;
          state_r <= S_D;
        end
        S_D: begin
          dx_r    <= zd_r ? '0 : mul_q;
          state_r <= S_E;
        end
        S_E: begin
          dy_r    <= zd_r ? '0 : alu_y;
          state_r <= S_F;
        end
        S_F: begin
          ta_r    <= alu_y;
          state_r <= S_G;
        end
        S_G: begin
          x_r     <= alu_y;
          tb_r    <= mul_q;
          state_r <= S_H;
        end
        S_H: begin
          ta_r    <= alu_y;
          dz_r    <= mul_q;
          state_r <= S_I;
        end
        S_I: begin
          y_r     <= alu_y;
          state_r <= S_J;
        end
        S_J: begin
          ta_r    <= alu_y;
          state_r <= S_K;
        end
        S_K: begin
          z_r     <= alu_y;
          state_r <= S_PK0;
        end
        S_PK0: begin
          tb_r    <= alu_y;
          peak_r  <= peak_max;
          state_r <= S_PK1;
        end
        S_PK1: begin
          peak_r  <= peak_max;
          state_r <= S_PK2;
        end
        S_PK2: begin
          // hold here while the previous result is still unread
          if (out_free) begin
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            out_z_r     <= z_r;
            out_peak_r  <= zd_r ? '0 : peak_max;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lesn_checker.sv -----
// port-level checker for the lorenz euler stepper, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module lesn_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // beats taken in minus beats delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + 2'd1;
    else if (!in_acc && out_acc) pend_nxt = pend_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `LESN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output beat changed while stalled")
  `LESN_ASSERT_NEXT(a_busy_after_in, in_acc, !in_tready, "input taken while an item is in work")
  `LESN_ASSERT(a_no_extra_out, out_acc |-> pend_r != 2'd0, "output beat without a pending input")
  `LESN_ASSERT(a_pend_bound, pend_r != 2'd3, "more than two items in flight")

endmodule

bind lorenz_euler_step_noise lesn_checker u_lesn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- test/lorenz_euler_step_noise_test.sv -----
// testbench for the lorenz euler stepper: directed table, random phases, self-checking predictor
module lorenz_euler_step_noise_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF        = 20;
  localparam int STALL_LIMIT     = 1000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 125;

  localparam longint WORD_TOP    = lesn_pkg::WMAX;
  localparam longint WORD_BOTTOM = lesn_pkg::WMIN;
  localparam longint UNIT        = longint'(1) << lesn_pkg::FRAC_BITS;

  localparam logic [lesn_pkg::CFG_AW-1:0] FIRST_SPARE_ADDR =
    lesn_pkg::CFG_AW'(lesn_pkg::CFG_ZERO_DRIFT + 1);
  localparam logic [lesn_pkg::CFG_AW-1:0] LAST_SPARE_ADDR  = '1;

  typedef enum logic {OP_STEP, OP_RESTART} step_op_t;
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // same layout as out_tdata
  typedef struct packed {
    logic            pad;
    lesn_pkg::peak_t peak;
    lesn_pkg::word_t z;
    lesn_pkg::word_t y;
    lesn_pkg::word_t x;
  } beat_t;

  typedef struct packed {
    row_kind_t                   kind;
    step_op_t                    op;
    lesn_pkg::word_t             nx;
    lesn_pkg::word_t             ny;
    lesn_pkg::word_t             nz;
    logic [lesn_pkg::CFG_AW-1:0] addr;
    logic [lesn_pkg::CFG_W-1:0]  value;
    logic                        known;
    beat_t                       want;
  } dir_row_t;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_tvalid   = 1'b0;
  logic                          in_tready;
  logic [95:0]                   in_tdata    = '0;  // noise_x, noise_y, noise_z
  logic                          in_tuser    = 1'b0; // opcode
  logic                          out_tvalid;
  logic                          out_tready  = 1'b0;
  logic [127:0]                  out_tdata;          // new_x, new_y, new_z, jacobian_peak, pad
  logic                          cfg_wr_en   = 1'b0;
  logic [lesn_pkg::CFG_AW-1:0]   cfg_addr    = '0;
  logic [lesn_pkg::CFG_W-1:0]    cfg_wr_data = '0;

  lorenz_euler_step_noise dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint px, py, pz;
  longint rho_r, sigma_r, beta_r, dt_r;
  logic   drift_off;

  beat_t  expected_points [$];
  bit     steady = 1'b0;
  int     mismatches = 0;
  int     results_seen = 0;
  int     steps_sent = 0;
  int     restarts_sent = 0;
  int     reg_writes = 0;
  int     clipped_results = 0;
  int     noise_only_results = 0;
  int     quiet_cycles = 0;

  function automatic longint clip_word(longint v);
    if (v > WORD_TOP) return WORD_TOP;
    if (v < WORD_BOTTOM) return WORD_BOTTOM;
    return v;
  endfunction

  function automatic longint add_clip(longint a, longint b);
    return clip_word(a + b);
  endfunction

  function automatic longint sub_clip(longint a, longint b);
    return clip_word(a - b);
  endfunction

  function automatic longint abs_clip(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return (m > WORD_TOP) ? WORD_TOP : m;
  endfunction

  // magnitude product, round half away from zero, then sign and clip
  function automatic longint mul_round(longint a, longint b);
    logic [63:0] ma, mb, m, cap;
    logic        neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    m   = (ma * mb + (64'd1 << (lesn_pkg::FRAC_BITS - 1))) >> lesn_pkg::FRAC_BITS;
    cap = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (m > cap) m = cap;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic beat_t next_point(step_op_t op, lesn_pkg::word_t nx,
                                       lesn_pkg::word_t ny, lesn_pkg::word_t nz);
    longint dx, dy, dz, best;
    longint cand [6];
    beat_t  nb;
    if (op == OP_RESTART) begin
      px = UNIT;
      py = UNIT;
      pz = UNIT;
    end else begin
      dx = 0;
      dy = 0;
      dz = 0;
      if (!drift_off) begin
        dx = mul_round(sigma_r, sub_clip(py, px));
        dy = sub_clip(mul_round(px, sub_clip(rho_r, pz)), py);
        dz = sub_clip(mul_round(px, py), mul_round(beta_r, pz));
      end
      px = add_clip(px, add_clip(mul_round(dx, dt_r), nx));
      py = add_clip(py, add_clip(mul_round(dy, dt_r), ny));
      pz = add_clip(pz, add_clip(mul_round(dz, dt_r), nz));
    end
    best = 0;
    if (!drift_off) begin
      cand = '{sigma_r, UNIT, beta_r, abs_clip(sub_clip(rho_r, pz)), abs_clip(px), abs_clip(py)};
      foreach (cand[i]) if (cand[i] > best) best = cand[i];
    end else begin
      noise_only_results++;
    end
    if (px == WORD_TOP || px == WORD_BOTTOM || py == WORD_TOP || py == WORD_BOTTOM ||
        pz == WORD_TOP || pz == WORD_BOTTOM)
      clipped_results++;
    nb.pad  = 1'b0;
    nb.peak = lesn_pkg::peak_t'(best);
    nb.x    = lesn_pkg::word_t'(px);
    nb.y    = lesn_pkg::word_t'(py);
    nb.z    = lesn_pkg::word_t'(pz);
    return nb;
  endfunction

  function automatic dir_row_t item_row(step_op_t op, lesn_pkg::word_t nx,
                                        lesn_pkg::word_t ny, lesn_pkg::word_t nz);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.op   = op;
    r.nx   = nx;
    r.ny   = ny;
    r.nz   = nz;
    return r;
  endfunction

  function automatic dir_row_t known_row(step_op_t op, lesn_pkg::word_t nx,
                                         lesn_pkg::word_t ny, lesn_pkg::word_t nz,
                                         lesn_pkg::word_t ex, lesn_pkg::word_t ey,
                                         lesn_pkg::word_t ez, lesn_pkg::peak_t pk);
    dir_row_t r;
    r       = item_row(op, nx, ny, nz);
    r.known = 1'b1;
    r.want  = '{pad: 1'b0, peak: pk, z: ez, y: ey, x: ex};
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [lesn_pkg::CFG_AW-1:0] addr,
                                       logic [lesn_pkg::CFG_W-1:0] value);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_REG;
    r.addr  = addr;
    r.value = value;
    return r;
  endfunction

  function automatic lesn_pkg::word_t draw_noise();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3, 4, 5: return lesn_pkg::word_t'($urandom_range(0, 8191)) - 4096;
      6, 7:    return lesn_pkg::word_t'($urandom_range(0, 2097151)) - 1048576;
      8:       return lesn_pkg::word_t'($urandom);
      default: return $urandom_range(0, 1) ? lesn_pkg::WMAX : lesn_pkg::WMIN;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  task automatic push_item(input step_op_t op, input lesn_pkg::word_t nx,
                           input lesn_pkg::word_t ny, input lesn_pkg::word_t nz,
                           input logic known, input beat_t typed);
    int    gap;
    beat_t calc;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {nz, ny, nx};
    do @(posedge clk); while (!in_tready);
    if (op == OP_RESTART) restarts_sent++;
    else steps_sent++;
    calc = next_point(op, nx, ny, nz);
    expected_points.push_back(known ? typed : calc);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
  endtask

  task automatic write_reg(input logic [lesn_pkg::CFG_AW-1:0] addr,
                           input logic [lesn_pkg::CFG_W-1:0] data);
    drain_results();
    repeat (HOLD_OFF) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= addr;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    case (addr)
      lesn_pkg::CFG_RHO:        rho_r = data[lesn_pkg::RHO_W-1:0];
      lesn_pkg::CFG_SIGMA:      sigma_r = data[lesn_pkg::SIGMA_W-1:0];
      lesn_pkg::CFG_BETA:       beta_r = data[lesn_pkg::BETA_W-1:0];
      lesn_pkg::CFG_DT:         dt_r = data[lesn_pkg::DT_W-1:0];
      lesn_pkg::CFG_ZERO_DRIFT: drift_off = data[0];
      default: ;
    endcase
  endtask

  // receiver: random stall after each beat, none in steady phases
  always @(posedge clk) begin : rx_pace
    int stall_left;
    int n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        n = steady ? 0 : $urandom_range(0, 5);
        if (n != 0) begin
          out_tready <= 1'b0;
          stall_left = n;
        end
      end
    end else if (stall_left > 1) begin
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    beat_t got;
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = beat_t'(out_tdata);
      if (expected_points.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat expected none, got %h", $time, out_tdata);
      end else begin
        want = expected_points.pop_front();
        check_field("new_x", want.x, got.x);
        check_field("new_y", want.y, got.y);
        check_field("new_z", want.z, got.z);
        check_field("jacobian_peak", want.peak, got.peak);
        check_field("pad", want.pad, got.pad);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_points.size());
      $display("lorenz_euler_step_noise_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t    directed_rows [$];
    longint      rho_set, sigma_set, beta_set, dt_set;
    logic        off_set;
    logic [31:0] junk;
    int          p;
    int          k;

    px        = UNIT;
    py        = UNIT;
    pz        = UNIT;
    rho_r     = 1638400;
    sigma_r   = 655360;
    beta_r    = 174763;
    dt_r      = 655;
    drift_off = 1'b0;

    directed_rows = '{
      // restart ignores its noise; peak is rho - z = 24.0 at defaults
      known_row(OP_RESTART, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'd1572864),
      item_row(OP_STEP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
      item_row(OP_STEP, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff),
      item_row(OP_STEP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
      item_row(OP_STEP, 32'h5555_5555, 32'haaaa_aaaa, 32'h0001_0000),
      item_row(OP_STEP, 32'hffff_0000, 32'h0000_ffff, 32'hffff_ffff),
      known_row(OP_RESTART, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'd1572864),
      // noise only: sums are plain saturating adds, peak is zero
      reg_row(lesn_pkg::CFG_ZERO_DRIFT, 23'd1),
      known_row(OP_STEP, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                32'h7fff_ffff, 32'h8001_0000, 32'h0001_0000, 31'd0),
      known_row(OP_STEP, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                32'h7fff_ffff, 32'h8000_0000, 32'h0000_ffff, 31'd0),
      known_row(OP_STEP, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'hffff_ffff, 32'hffff_ffff, 32'h8000_ffff, 31'd0),
      known_row(OP_RESTART, 32'h1234_5678, 32'h0000_0001, 32'hffff_ffff,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'd0),
      // only bit 0 of the mode register counts
      reg_row(lesn_pkg::CFG_ZERO_DRIFT, 23'h7f_fffe),
      // all-ones writes, above the usual range and past the beta and dt register widths
      reg_row(lesn_pkg::CFG_RHO, 23'h7f_ffff),
      reg_row(lesn_pkg::CFG_SIGMA, 23'h7f_ffff),
      reg_row(lesn_pkg::CFG_BETA, 23'h7f_ffff),
      reg_row(lesn_pkg::CFG_DT, 23'h7f_ffff),
      known_row(OP_RESTART, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h7f_ffff),
      item_row(OP_STEP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
      item_row(OP_STEP, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f),
      reg_row(lesn_pkg::CFG_RHO, 23'd0),
      reg_row(lesn_pkg::CFG_SIGMA, 23'd0),
      reg_row(lesn_pkg::CFG_BETA, 23'd0),
      reg_row(lesn_pkg::CFG_DT, 23'd0),
      known_row(OP_RESTART, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h1_0000),
      // writes to unmapped addresses change nothing
      reg_row(FIRST_SPARE_ADDR, 23'h7f_ffff),
      reg_row(LAST_SPARE_ADDR, 23'h7f_ffff),
      // zero time step: the point stays put
      known_row(OP_STEP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h1_0000),
      item_row(OP_STEP, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0002)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG)
        write_reg(directed_rows[i].addr, directed_rows[i].value);
      else
        push_item(directed_rows[i].op, directed_rows[i].nx, directed_rows[i].ny,
                  directed_rows[i].nz, directed_rows[i].known, directed_rows[i].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          rho_set = 1638400; sigma_set = 655360; beta_set = 174763; dt_set = 655;
          off_set = 1'b0;
        end
        1: begin
          rho_set = 6553600; sigma_set = 6553600; beta_set = 655360; dt_set = 65536;
          off_set = 1'b0;
        end
        2: begin
          rho_set = 0; sigma_set = 0; beta_set = 0; dt_set = 0;
          off_set = 1'b1;
        end
        default: begin
          rho_set   = $urandom_range(0, 6553600);
          sigma_set = $urandom_range(0, 6553600);
          beta_set  = $urandom_range(0, 655360);
          dt_set    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65536)
                                                  : $urandom_range(0, 1500);
          off_set   = ($urandom_range(0, 3) == 0);
        end
      endcase
      // junk above the beta, dt and mode register widths must be dropped
      junk = $urandom;
      write_reg(lesn_pkg::CFG_RHO, lesn_pkg::CFG_W'(rho_set));
      write_reg(lesn_pkg::CFG_SIGMA, lesn_pkg::CFG_W'(sigma_set));
      write_reg(lesn_pkg::CFG_BETA,
                lesn_pkg::CFG_W'(beta_set) | lesn_pkg::CFG_W'(junk << lesn_pkg::BETA_W));
      write_reg(lesn_pkg::CFG_DT,
                lesn_pkg::CFG_W'(dt_set) | lesn_pkg::CFG_W'(junk << lesn_pkg::DT_W));
      write_reg(lesn_pkg::CFG_ZERO_DRIFT,
                lesn_pkg::CFG_W'(off_set) | lesn_pkg::CFG_W'(junk << 1));

      steady = (p == 2 || p == 5);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ((p == 3 && k == ITEMS_PER_PHASE / 2) || $urandom_range(0, 99) == 0)
          drain_results();
        push_item(step_op_t'(($urandom_range(0, 11) == 0) ? OP_RESTART : OP_STEP),
                  draw_noise(), draw_noise(), draw_noise(), 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (HOLD_OFF) @(posedge clk);

    $display("covered %0d steps and %0d restarts with %0d register writes, %0d results checked",
             steps_sent, restarts_sent, reg_writes, results_seen);
    $display("%0d results hit the word limits, %0d came from noise-only mode",
             clipped_results, noise_only_results);
    if (mismatches == 0)
      $display("lorenz_euler_step_noise_test: clean");
    else
      $display("lorenz_euler_step_noise_test: errors");
    $finish;
  end

endmodule
